// ----- rtl/sorted_table_bound_search_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table bound search.
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BOUND_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BOUND_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sbs_pkg.sv -----
// ----------------------------------------------------------------------------
// sbs_pkg
// Request codes, controller states and control structs of the bound search.
// ----------------------------------------------------------------------------
package sbs_pkg;

	typedef enum logic [2:0] {
		KIND_CLEAR  = 3'd0,
		KIND_APPEND = 3'd1,
		KIND_LOWER  = 3'd2,
		KIND_UPPER  = 3'd3,
		KIND_FLOOR  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic start;
		logic floor_mode;
		logic upper_mode;
		logic probe;
		logic update;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic window_open;
	} status_t;

endpackage

// ----- rtl/sbs_ram.sv -----
// ----------------------------------------------------------------------------
// sbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/sbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbs_ctrl
// Controller: takes requests, steps the search loop and hands off results.
// ----------------------------------------------------------------------------
module sbs_ctrl
	import sbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  kind,
	output logic        result_valid,
	input  logic        result_ready,
	output cmd_t        cmd,
	input  status_t     status
);

	state_t state_q, state_d;
	logic   result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (kind) inside
						KIND_CLEAR:  cmd.clear = 1'b1;
						KIND_APPEND: cmd.append = 1'b1;
						KIND_LOWER, KIND_UPPER, KIND_FLOOR: begin
							cmd.start      = 1'b1;
							cmd.floor_mode = (kind == KIND_FLOOR);
							cmd.upper_mode = (kind == KIND_UPPER);
							state_d        = ST_PROBE;
						end
						default: ;
					endcase
				end
			end
			ST_PROBE: begin
				if (status.window_open) begin
					cmd.probe = 1'b1;
					state_d   = ST_CMP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CMP: begin
				cmd.update = 1'b1;
				state_d    = ST_PROBE;
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign result_valid = result_valid_q;

endmodule

// ----- rtl/sbs_dp.sv -----
// ----------------------------------------------------------------------------
// sbs_dp
// Datapath: entry table, count, search window, compare and result registers.
// ----------------------------------------------------------------------------
module sbs_dp
	import sbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cmd_t                                 cmd,
	output status_t                              status,
	input  logic signed [DATA_WIDTH-1:0]         item_value,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]     bound_index,
	output logic signed [DATA_WIDTH-1:0]         floor_value,
	output logic                                 floor_found
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [CW-1:0]                count_q;
	logic [CW-1:0]                lo_q;
	logic [CW-1:0]                hi_q;
	logic [CW-1:0]                mid_q;
	logic [CW:0]                  mid_sum;
	logic [CW-1:0]                mid;
	logic signed [DATA_WIDTH-1:0] target_q;
	logic                         floor_q;
	logic                         upper_q;
	logic                         found_q;
	logic signed [DATA_WIDTH-1:0] fval_q;
	logic [CW-1:0]                bound_index_q;
	logic signed [DATA_WIDTH-1:0] floor_value_q;
	logic                         floor_found_q;
	logic [DATA_WIDTH-1:0]        rd_data;
	logic signed [DATA_WIDTH-1:0] entry;
	logic                         not_full;
	logic                         wr_en;
	logic                         gt;
	logic                         ge;
	logic                         go_left;

	// The window is half open, [lo, hi); the probe is the floor of the
	// midpoint of the matching inclusive window.
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
	assign mid      = mid_sum[CW:1];
	assign not_full = (count_q < CW'(TABLE_DEPTH));
	assign wr_en    = cmd.append && not_full;

	sbs_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (item_value),
		.raddr (mid[AW-1:0]),
		.rdata (rd_data)
	);

	assign entry   = $signed(rd_data);
	assign gt      = (entry > target_q);
	assign ge      = (entry >= target_q);
	assign go_left = (floor_q || upper_q) ? gt : ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_q     <= '0;
			hi_q     <= count_q;
			target_q <= item_value;
			floor_q  <= cmd.floor_mode;
			upper_q  <= cmd.upper_mode;
			found_q  <= 1'b0;
			fval_q   <= '0;
		end
		if (cmd.probe) begin
			mid_q <= mid;
		end
		if (cmd.update) begin
			if (go_left) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + {{(CW-1){1'b0}}, 1'b1};
			end
			if (floor_q && !gt) begin
				found_q <= 1'b1;
				fval_q  <= entry;
			end
		end
		if (cmd.publish) begin
			bound_index_q <= floor_q ? '0 : hi_q;
			floor_value_q <= fval_q;
			floor_found_q <= found_q;
		end
	end

	assign status.window_open = (lo_q < hi_q);
	assign bound_index        = bound_index_q;
	assign floor_value        = floor_value_q;
	assign floor_found        = floor_found_q;

endmodule

// ----- rtl/sorted_table_bound_search.sv -----
// ----------------------------------------------------------------------------
// sorted_table_bound_search
// Binary search over a table of signed words loaded in ascending order.
// ----------------------------------------------------------------------------
// Clear and append requests give no result. A lower bound, upper bound or floor
// query runs a binary search with one table read per probe; the single read port
// of the table and its registered read make each probe pass through a probe state
// and a compare state. One request is in work at a time, and the next request can
// be taken in the same cycle as the result becomes valid; a finished result sits
// in an output register, so the next request is taken while the result waits.
module sorted_table_bound_search
	import sbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic [2:0]                       kind,
	input  logic signed [DATA_WIDTH-1:0]     item_value,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [$clog2(TABLE_DEPTH+1)-1:0] bound_index,
	output logic signed [DATA_WIDTH-1:0]     floor_value,
	output logic                             floor_found
);

	cmd_t    cmd;
	status_t status;

	sbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.status       (status)
	);

	sbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.item_value  (item_value),
		.bound_index (bound_index),
		.floor_value (floor_value),
		.floor_found (floor_found)
	);

endmodule

// ----- rtl/sbs_checker.sv -----
// ----------------------------------------------------------------------------
// sbs_checker
// Port-level checks of the bound search, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_table_bound_search_assert.svh"

module sbs_checker
	import sbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int DATA_WIDTH  = 32
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             item_valid,
	input logic                             item_ready,
	input logic [2:0]                       kind,
	input logic signed [DATA_WIDTH-1:0]     item_value,
	input logic                             result_valid,
	input logic                             result_ready,
	input logic [$clog2(TABLE_DEPTH+1)-1:0] bound_index,
	input logic signed [DATA_WIDTH-1:0]     floor_value,
	input logic                             floor_found
);

	`SBS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(bound_index) && $stable(floor_value) && $stable(floor_found), "Stalled result changed.")
	`SBS_ASSERT_NEXT(a_query_busy, item_valid && item_ready && (kind == KIND_LOWER || kind == KIND_UPPER || kind == KIND_FLOOR), !item_ready, "Request taken during a search.")
	`SBS_ASSERT_NOW(a_floor_zero, result_valid && !floor_found, floor_value == '0, "Floor value without a match.")
	`SBS_ASSERT_NOW(a_index_range, result_valid, (bound_index <= TABLE_DEPTH) && !((bound_index != '0) && floor_found), "Result index out of range or mixed with a floor.")

endmodule

bind sorted_table_bound_search sbs_checker #(
	.TABLE_DEPTH (TABLE_DEPTH),
	.DATA_WIDTH  (DATA_WIDTH)
) u_sbs_checker (.*);
